FILE: rtl/core/reb_pkg.sv
// Shared types and constants for the rotary encoder with button block.
// No dependencies.
package reb_pkg;

	localparam int CMD_W = 2;
	localparam int COUNT_W = 15;
	localparam int DEB_W = 16;
	localparam int TIME_W = 32;
	localparam int NV_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_POLL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;

	localparam logic [COUNT_W-1:0] MAX_VALUE_RST = 15'd32767;
	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd50;

	// bit i set when transition code i is a legal quadrature move
	localparam logic [15:0] VALID_MOVE = 16'h6996;
	localparam logic [7:0] HIST_DOWN = 8'hbd;
	localparam logic [7:0] HIST_UP = 8'h17;

	typedef struct packed {
		logic up;
		logic down;
	} step_t;

endpackage

FILE: rtl/core/reb_if.sv
// Handshake channels for the rotary encoder block: items, results, config writes.
// Depends on reb_pkg.
interface reb_in_if;
	logic valid;
	logic ready;
	logic [reb_pkg::CMD_W-1:0] cmd;
	logic data_level;
	logic clock_level;
	logic button_level;
	logic [reb_pkg::TIME_W-1:0] now_ms;
	logic [reb_pkg::NV_W-1:0] new_value;

	modport source (output valid, cmd, data_level, clock_level, button_level, now_ms,
		new_value, input ready);
	modport sink (input valid, cmd, data_level, clock_level, button_level, now_ms,
		new_value, output ready);
endinterface

interface reb_out_if;
	logic valid;
	logic ready;
	logic new_flag;
	logic [reb_pkg::COUNT_W-1:0] count_value;
	logic button_pressed;

	modport source (output valid, new_flag, count_value, button_pressed, input ready);
	modport sink (input valid, new_flag, count_value, button_pressed, output ready);
endinterface

interface reb_cfg_if;
	logic valid;
	logic ready;
	logic [reb_pkg::CFG_IDX_W-1:0] index;
	logic [reb_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/reb_decode.sv
// Quadrature transition decoder: next transition code, history and step.
// Depends on reb_pkg.
module reb_decode (
	input  logic [3:0] code,
	input  logic [7:0] hist,
	input  logic data_level,
	input  logic clock_level,
	output logic [3:0] code_next,
	output logic [7:0] hist_next,
	output reb_pkg::step_t step
);

	logic legal;

	always_comb begin
		code_next = {code[1:0], data_level, clock_level};
		legal = reb_pkg::VALID_MOVE[code_next];
		hist_next = legal ? {hist[3:0], code_next} : hist;
		step.down = legal && (hist_next == reb_pkg::HIST_DOWN);
		step.up = legal && (hist_next == reb_pkg::HIST_UP);
	end

endmodule

FILE: rtl/core/rotary_encoder_with_button.sv
// Rotary encoder decoder with debounced push button, top level.
// Depends on reb_pkg, reb_if and reb_decode.
//
// Each word on the item channel is a poll, a set-value request or a press-flag clear,
// and yields one result word. An item is captured in an input register and processed
// into the result register when that register is free or being read, so one item is
// taken per clock; the only limit is the result side's ready. Config writes are always
// taken and should only be issued while idle.
module rotary_encoder_with_button (
	input  logic clk,
	input  logic arst_n,
	reb_in_if.sink item,
	reb_out_if.source result,
	reb_cfg_if.sink cfg
);

	logic [reb_pkg::COUNT_W-1:0] max_q;
	logic [reb_pkg::DEB_W-1:0] deb_q;

	logic vld_s1;
	logic [reb_pkg::CMD_W-1:0] cmd_s1;
	logic data_s1;
	logic clk_s1;
	logic btn_s1;
	logic [reb_pkg::TIME_W-1:0] now_s1;
	logic [reb_pkg::NV_W-1:0] nv_s1;

	logic [3:0] code_q;
	logic [7:0] hist_q;
	logic [reb_pkg::COUNT_W-1:0] count_q;
	logic held_q;
	logic latched_q;
	logic [reb_pkg::TIME_W-1:0] release_q;
	logic pend_q;

	logic res_vld_q;
	logic res_new_q;
	logic [reb_pkg::COUNT_W-1:0] res_count_q;
	logic res_press_q;

	logic adv;
	logic take;
	logic [3:0] code_next;
	logic [7:0] hist_next;
	reb_pkg::step_t step;
	logic pressed_now;
	logic [reb_pkg::TIME_W-1:0] elapsed;
	logic press_ev;
	logic [reb_pkg::COUNT_W:0] sum;
	logic [reb_pkg::COUNT_W-1:0] count_poll;

	assign adv = vld_s1 && (!res_vld_q || result.ready);
	assign item.ready = !vld_s1 || adv;
	assign take = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	assign result.valid = res_vld_q;
	assign result.new_flag = res_new_q;
	assign result.count_value = res_count_q;
	assign result.button_pressed = res_press_q;

	reb_decode u_decode (
		.code(code_q),
		.hist(hist_q),
		.data_level(data_s1),
		.clock_level(clk_s1),
		.code_next(code_next),
		.hist_next(hist_next),
		.step(step)
	);

	always_comb begin
		pressed_now = !btn_s1;
		elapsed = now_s1 - release_q;
		press_ev = !held_q && pressed_now && (elapsed > {16'd0, deb_q});
		sum = {1'b0, count_q};
		if (step.up) begin
			sum = {1'b0, count_q} + 16'd1;
		end else if (step.down && count_q != '0) begin
			sum = {1'b0, count_q} - 16'd1;
		end
		count_poll = (sum > {1'b0, max_q}) ? max_q : sum[reb_pkg::COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= reb_pkg::MAX_VALUE_RST;
			deb_q <= reb_pkg::DEBOUNCE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				reb_pkg::CFG_MAX_VALUE: max_q <= cfg.data[reb_pkg::COUNT_W-1:0];
				reb_pkg::CFG_DEBOUNCE: deb_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= item.cmd;
			data_s1 <= item.data_level;
			clk_s1 <= item.clock_level;
			btn_s1 <= item.button_level;
			now_s1 <= item.now_ms;
			nv_s1 <= item.new_value;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			hist_q <= '0;
			count_q <= '0;
			held_q <= 1'b0;
			latched_q <= 1'b0;
			release_q <= '0;
			pend_q <= 1'b0;
		end else if (adv) begin
			case (cmd_s1)
				reb_pkg::CMD_POLL: begin
					code_q <= code_next;
					hist_q <= hist_next;
					count_q <= count_poll;
					pend_q <= 1'b0;
					if (press_ev) begin
						held_q <= 1'b1;
						latched_q <= 1'b1;
						release_q <= now_s1;
					end
					if (!pressed_now) begin
						held_q <= 1'b0;
						release_q <= now_s1;
					end
				end
				reb_pkg::CMD_SET: begin
					count_q <= {{(reb_pkg::COUNT_W-reb_pkg::NV_W){1'b0}}, nv_s1};
					pend_q <= 1'b1;
				end
				reb_pkg::CMD_CLEAR: begin
					latched_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (cmd_s1)
				reb_pkg::CMD_POLL: begin
					res_new_q <= step.up || step.down || pend_q;
					res_count_q <= count_poll;
					res_press_q <= latched_q || press_ev;
				end
				reb_pkg::CMD_SET: begin
					res_new_q <= 1'b0;
					res_count_q <= {{(reb_pkg::COUNT_W-reb_pkg::NV_W){1'b0}}, nv_s1};
					res_press_q <= latched_q;
				end
				reb_pkg::CMD_CLEAR: begin
					res_new_q <= 1'b0;
					res_count_q <= count_q;
					res_press_q <= 1'b0;
				end
				default: begin
					res_new_q <= 1'b0;
					res_count_q <= count_q;
					res_press_q <= latched_q;
				end
			endcase
		end
	end

	a_poll_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_s1 == reb_pkg::CMD_POLL |=> !pend_q)
		else $error("set flag survived a poll");

	a_latch_fall_by_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(latched_q) |-> $past(adv) && $past(cmd_s1) == reb_pkg::CMD_CLEAR)
		else $error("press flag dropped without a clear");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(adv))
		else $error("result raised without an item");

	a_state_moves_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(count_q) && $stable(hist_q))
		else $error("state changed with no item advancing");

endmodule
